FILE: rtl/spcc_pkg.sv
`default_nettype none

package spcc_pkg;

  // Fixed field widths of the item and result ports
  localparam int XY_W   = 10;
  localparam int LINK_W = 10;
  // Major axis span of one filled gap, wide enough for the largest allowed gap
  localparam int GAP_W  = 7;

  localparam logic [LINK_W-1:0] COUNT_MAX    = '1;
  localparam logic [LINK_W-1:0] SHORT_STROKE = LINK_W'(3);

  // Operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_GAP   = 2'd2;

  typedef enum logic {
    KIND_SINGLE,
    KIND_LINE
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_STEP
  } back_state_t;

  typedef struct packed {
    logic signed [1:0] step_dx;
    logic signed [1:0] step_dy;
    logic              step_valid;
    logic [1:0]        status;
    logic              stroke_replaced;
    logic [LINK_W-1:0] link_count;
    logic              last;
  } res_t;

  typedef struct packed {
    cmd_kind_t         kind;
    res_t              single;
    logic              x_major;
    logic              neg_x;
    logic              neg_y;
    logic [GAP_W-1:0]  major;
    logic [GAP_W-1:0]  minor;
    logic [LINK_W-1:0] links_base;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/spcc_fifo.sv
`default_nettype none

module spcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spcc_front.sv
`default_nettype none

module spcc_front #(
  parameter int MAX_LINKS  = 500,
  parameter int MAX_GAP    = 64,
  parameter int COORD_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [1:0]                 operation,
  input  wire logic [spcc_pkg::XY_W-1:0]  x,
  input  wire logic [spcc_pkg::XY_W-1:0]  y,
  output spcc_pkg::cmd_t                  cmd
);

  localparam int CW     = (COORD_BITS < spcc_pkg::XY_W) ? COORD_BITS : spcc_pkg::XY_W;
  localparam int GAP_W  = spcc_pkg::GAP_W;
  localparam int LINK_W = spcc_pkg::LINK_W;

  logic [CW-1:0]     prev_x_r, prev_x_nxt;
  logic [CW-1:0]     prev_y_r, prev_y_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic [LINK_W-1:0] links_r, links_nxt;

  logic [CW-1:0]        px, py;
  logic signed [CW:0]   dxs, dys, neg_dx, neg_dy;
  logic [CW-1:0]        adx, ady, major_f, minor_f;
  logic                 x_major, near, same, too_wide;
  logic [GAP_W-1:0]     major_g, minor_g;
  logic [LINK_W:0]      line_sum;
  logic [LINK_W-1:0]    links_inc;

  assign px = x[CW-1:0];
  assign py = y[CW-1:0];

  always_comb begin
    dxs      = $signed({1'b0, px}) - $signed({1'b0, prev_x_r});
    dys      = $signed({1'b0, py}) - $signed({1'b0, prev_y_r});
    neg_dx   = -dxs;
    neg_dy   = -dys;
    adx      = dxs[CW] ? neg_dx[CW-1:0] : dxs[CW-1:0];
    ady      = dys[CW] ? neg_dy[CW-1:0] : dys[CW-1:0];
    x_major  = (adx >= ady);
    major_f  = x_major ? adx : ady;
    minor_f  = x_major ? ady : adx;
    near     = (adx <= CW'(1)) && (ady <= CW'(1));
    same     = (adx == '0) && (ady == '0);
    too_wide = ({{GAP_W{1'b0}}, major_f} > (CW + GAP_W)'(MAX_GAP));
    major_g  = GAP_W'({{GAP_W{1'b0}}, major_f});
    minor_g  = GAP_W'({{GAP_W{1'b0}}, minor_f});
    line_sum = {1'b0, links_r} + (LINK_W + 1)'(major_g);
    links_inc = (links_r == spcc_pkg::COUNT_MAX) ? links_r : links_r + LINK_W'(1);
  end

  // Classify the item and work out the state it leaves behind
  always_comb begin
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    has_prev_nxt = has_prev_r;
    links_nxt    = links_r;

    cmd                        = '0;
    cmd.kind                   = spcc_pkg::KIND_SINGLE;
    cmd.single.status          = spcc_pkg::ST_OK;
    cmd.single.last            = 1'b1;
    cmd.x_major                = x_major;
    cmd.neg_x                  = dxs[CW];
    cmd.neg_y                  = dys[CW];
    cmd.major                  = major_g;
    cmd.minor                  = minor_g;
    cmd.links_base             = links_r;

    unique case (operation)
      spcc_pkg::OP_BEGIN: begin
        prev_x_nxt   = px;
        prev_y_nxt   = py;
        has_prev_nxt = 1'b1;
        links_nxt    = '0;
      end
      spcc_pkg::OP_END: begin
        if (links_r < spcc_pkg::SHORT_STROKE) begin
          links_nxt                  = LINK_W'(1);
          cmd.single.step_dx         = 2'sd1;
          cmd.single.step_valid      = 1'b1;
          cmd.single.stroke_replaced = 1'b1;
        end
      end
      spcc_pkg::OP_ADD: begin
        priority if (links_r > LINK_W'(MAX_LINKS)) begin
          cmd.single.status = spcc_pkg::ST_LIMIT;
        end else if (!has_prev_r) begin
          prev_x_nxt   = px;
          prev_y_nxt   = py;
          has_prev_nxt = 1'b1;
        end else if (same) begin
          // repeated point: a result without a link
        end else if (near) begin
          links_nxt             = links_inc;
          prev_x_nxt            = px;
          prev_y_nxt            = py;
          cmd.single.step_valid = 1'b1;
          cmd.single.step_dx    = (adx == '0) ? 2'sd0 : (dxs[CW] ? -2'sd1 : 2'sd1);
          cmd.single.step_dy    = (ady == '0) ? 2'sd0 : (dys[CW] ? -2'sd1 : 2'sd1);
        end else if (too_wide) begin
          cmd.single.status = spcc_pkg::ST_GAP;
        end else begin
          cmd.kind   = spcc_pkg::KIND_LINE;
          links_nxt  = line_sum[LINK_W] ? spcc_pkg::COUNT_MAX : line_sum[LINK_W-1:0];
          prev_x_nxt = px;
          prev_y_nxt = py;
        end
      end
      default: begin
      end
    endcase

    cmd.single.link_count = links_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      has_prev_r <= 1'b0;
      links_r    <= '0;
    end else if (accept) begin
      prev_x_r   <= prev_x_nxt;
      prev_y_r   <= prev_y_nxt;
      has_prev_r <= has_prev_nxt;
      links_r    <= links_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spcc_back.sv
`default_nettype none

module spcc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_empty,
  input  wire spcc_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output spcc_pkg::res_t      res
);

  localparam int GAP_W  = spcc_pkg::GAP_W;
  localparam int LINK_W = spcc_pkg::LINK_W;

  spcc_pkg::back_state_t state_r, state_nxt;

  logic              x_major_r, x_major_nxt;
  logic              neg_x_r, neg_x_nxt;
  logic              neg_y_r, neg_y_nxt;
  logic [GAP_W-1:0]  major_r, major_nxt;
  logic [GAP_W-1:0]  minor_r, minor_nxt;
  logic [GAP_W-1:0]  err_r, err_nxt;
  logic [GAP_W-1:0]  k_r, k_nxt;
  logic [LINK_W-1:0] count_r, count_nxt;

  logic [GAP_W:0]    err_sum, err_sub;
  logic              side;
  logic [GAP_W-1:0]  k_inc;
  logic [LINK_W-1:0] count_inc;
  logic signed [1:0] sx, sy;

  always_comb begin
    err_sum   = {1'b0, err_r} + {1'b0, minor_r};
    err_sub   = err_sum - {1'b0, major_r};
    side      = (err_sum > {1'b0, major_r});
    k_inc     = k_r + GAP_W'(1);
    count_inc = (count_r == spcc_pkg::COUNT_MAX) ? count_r : count_r + LINK_W'(1);
    sx        = neg_x_r ? -2'sd1 : 2'sd1;
    sy        = neg_y_r ? -2'sd1 : 2'sd1;
  end

  always_comb begin
    state_nxt   = state_r;
    x_major_nxt = x_major_r;
    neg_x_nxt   = neg_x_r;
    neg_y_nxt   = neg_y_r;
    major_nxt   = major_r;
    minor_nxt   = minor_r;
    err_nxt     = err_r;
    k_nxt       = k_r;
    count_nxt   = count_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = cmd.single;

    unique case (state_r)
      spcc_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.kind == spcc_pkg::KIND_LINE) begin
            // load the stepper; links follow from the BK_STEP state
            cmd_pop     = 1'b1;
            x_major_nxt = cmd.x_major;
            neg_x_nxt   = cmd.neg_x;
            neg_y_nxt   = cmd.neg_y;
            major_nxt   = cmd.major;
            minor_nxt   = cmd.minor;
            err_nxt     = cmd.minor;
            k_nxt       = '0;
            count_nxt   = cmd.links_base;
            state_nxt   = spcc_pkg::BK_STEP;
          end else if (!res_full) begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
          end
        end
      end
      spcc_pkg::BK_STEP: begin
        res                 = '0;
        res.status          = spcc_pkg::ST_OK;
        res.step_valid      = 1'b1;
        res.step_dx         = (x_major_r || side) ? sx : 2'sd0;
        res.step_dy         = (!x_major_r || side) ? sy : 2'sd0;
        res.link_count      = count_inc;
        res.last            = (k_inc == major_r);
        if (!res_full) begin
          res_push  = 1'b1;
          err_nxt   = side ? err_sub[GAP_W-1:0] : err_sum[GAP_W-1:0];
          k_nxt     = k_inc;
          count_nxt = count_inc;
          if (k_inc == major_r) begin
            state_nxt = spcc_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = spcc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spcc_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_major_r <= x_major_nxt;
    neg_x_r   <= neg_x_nxt;
    neg_y_r   <= neg_y_nxt;
    major_r   <= major_nxt;
    minor_r   <= minor_nxt;
    err_r     <= err_nxt;
    k_r       <= k_nxt;
    count_r   <= count_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/stroke_point_to_chain_code.sv
`default_nettype none

// Stroke point to chain-code converter. Feed the pen points of a handwriting
// stroke (operation begin, add, end) through the push/full queue port and pop
// unit chain-code links from the result queue port. Every item gives at least
// one result; the final result of an item carries last. A begin, an end, a
// refused or repeated add, and an add one pixel from the previous point give
// one result each; an add farther away is filled with a stepped straight line
// and gives one link per step along the larger axis (up to MAX_GAP links).
// Timing: the front end takes one item per cycle while the two-entry command
// queue has room; the back end passes each single result on as it is popped,
// and loads a gap into the DDA stepper, which then gives one link per cycle
// while the result queue has room. Results wait in a two-entry output queue,
// so the stepper can run ahead of a stalled consumer until that queue fills.
module stroke_point_to_chain_code #(
  parameter int MAX_LINKS  = 500,
  parameter int MAX_GAP    = 64,
  parameter int COORD_BITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // item side
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [1:0]                          in_operation,
  input  wire logic [spcc_pkg::XY_W-1:0]           in_x,
  input  wire logic [spcc_pkg::XY_W-1:0]           in_y,
  // result side
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [1:0]                        out_step_dx,
  output logic signed [1:0]                        out_step_dy,
  output logic                                     out_step_valid,
  output logic [1:0]                               out_status,
  output logic                                     out_stroke_replaced,
  output logic [spcc_pkg::LINK_W-1:0]              out_link_count,
  output logic                                     out_last
);

  localparam int CMD_W = $bits(spcc_pkg::cmd_t);
  localparam int RES_W = $bits(spcc_pkg::res_t);

  spcc_pkg::cmd_t cmd_in, cmd_out;
  spcc_pkg::res_t res_in, res_out;
  logic           in_accept;
  logic           cmd_empty, cmd_pop;
  logic           res_full, res_push;

  // accept a beat whenever the command queue has room
  assign in_accept = push && !full;

  spcc_front #(
    .MAX_LINKS  (MAX_LINKS),
    .MAX_GAP    (MAX_GAP),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .operation (in_operation),
    .x         (in_x),
    .y         (in_y),
    .cmd       (cmd_in)
  );

  // decouple classification from the stepper
  spcc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  spcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // hold results for the consumer so the stepper can run ahead
  spcc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_step_dx         = res_out.step_dx;
  assign out_step_dy         = res_out.step_dy;
  assign out_step_valid      = res_out.step_valid;
  assign out_status          = res_out.status;
  assign out_stroke_replaced = res_out.stroke_replaced;
  assign out_link_count      = res_out.link_count;
  assign out_last            = res_out.last;

`ifndef SYNTHESIS
  // the back end never pushes into a full result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed while result queue full");

  // a result without a link carries no move
  a_no_move_without_link: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_step_valid) |-> (out_step_dx == 2'sd0 && out_step_dy == 2'sd0))
    else $error("move on a result without a link");

  // a refused add is a single result without a link
  a_refusal_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != spcc_pkg::ST_OK) |-> (out_last && !out_step_valid))
    else $error("refused item produced a link or more results");

  // a popped command is consumed only when it is present
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire
